/* rtl/mppt_po_pkg.sv */
// Shared types and constants of the perturb-and-observe tracker.
`timescale 1ns / 1ps
package mppt_po_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_SUM,
    ST_AVG,
    ST_PWR,
    ST_STEP,
    ST_ERR,
    ST_MULI,
    ST_INTEG,
    ST_DUTY,
    ST_MULC,
    ST_FIN
  } mppt_state_e;

  typedef enum logic [2:0] {
    REG_KP          = 3'd0,
    REG_KI_TS       = 3'd1,
    REG_V_STEP      = 3'd2,
    REG_V_MAX       = 3'd3,
    REG_V_MIN       = 3'd4,
    REG_PWM_PERIOD  = 3'd5,
    REG_MPPT_PERIOD = 3'd6,
    REG_DUTY_LIMIT  = 3'd7
  } mppt_reg_e;

  // moving-average depth, a power of two so the mean is an arithmetic shift
  localparam int AVG_DEPTH = 128;

  localparam logic [31:0] KP_RST          = 32'd16777;
  localparam logic [31:0] KI_TS_RST       = 32'd8389;
  localparam logic [22:0] V_STEP_RST      = 23'd6554;
  localparam logic [24:0] V_MAX_RST       = 25'd3145728;
  localparam logic [24:0] V_MIN_RST       = 25'd1310720;
  localparam logic [15:0] PWM_PERIOD_RST  = 16'd1875;
  localparam logic [23:0] MPPT_PERIOD_RST = 24'd2000;
  localparam logic [24:0] DUTY_LIMIT_RST  = 25'd15099494;
  localparam logic [31:0] VREF_RST        = 32'd1966080;

  localparam int MUL_W = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam logic signed [27:0] INC_MAX = 28'sd67108864;

endpackage

/* rtl/mppt_perturb_observe_pi.sv */
// Perturb-and-observe maximum power point tracker with PI voltage loop.
`timescale 1ns / 1ps
// One input word is one sample tick and yields exactly one result word. The
// filtered voltage and current go into one ring memory (one entry holds both
// samples, read into a register when the word is accepted); running sums
// give the moving averages over AVG_DEPTH samples (a power of two, so the
// mean is a shift), and unwritten entries read as zero through a fill
// flag, so no clearing pass is needed. A single shared 34 x 34 multiplier
// is used in turn for power, the integral term, the proportional term and
// the compare count. A tick runs read, sum and average, then, with the
// converter on, power and step when armed and enabled, error, integral,
// proportional, duty and compare, and ends in the final state, which
// waits while the output stalls. A new word is taken once the previous
// result sits in the output register.
module mppt_perturb_observe_pi (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  pv_voltage_i,
  input  logic signed [31:0]  filt_voltage_i,
  input  logic signed [31:0]  filt_current_i,
  input  logic                converter_on_i,
  input  logic                mppt_enable_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         compare_value_o,
  output logic signed [31:0]  voltage_reference_o,
  output logic signed [31:0]  average_voltage_o,
  output logic signed [31:0]  average_current_o,
  output logic                mppt_stepped_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import mppt_po_pkg::*;

  localparam int IDX_W = $clog2(AVG_DEPTH);
  localparam int SUM_W = 32 + IDX_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(AVG_DEPTH - 1);

  // configuration
  logic [31:0] kp_q, ki_ts_q;
  logic [22:0] v_step_q;
  logic [24:0] v_max_q, v_min_q, duty_limit_q;
  logic [15:0] pwm_period_q;
  logic [23:0] mppt_period_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q          <= KP_RST;
      ki_ts_q       <= KI_TS_RST;
      v_step_q      <= V_STEP_RST;
      v_max_q       <= V_MAX_RST;
      v_min_q       <= V_MIN_RST;
      pwm_period_q  <= PWM_PERIOD_RST;
      mppt_period_q <= MPPT_PERIOD_RST;
      duty_limit_q  <= DUTY_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (mppt_reg_e'(cfg_index_i))
        REG_KP:          kp_q          <= cfg_data_i;
        REG_KI_TS:       ki_ts_q       <= cfg_data_i;
        REG_V_STEP:      v_step_q      <= cfg_data_i[22:0];
        REG_V_MAX:       v_max_q       <= cfg_data_i[24:0];
        REG_V_MIN:       v_min_q       <= cfg_data_i[24:0];
        REG_PWM_PERIOD:  pwm_period_q  <= cfg_data_i[15:0];
        REG_MPPT_PERIOD: mppt_period_q <= cfg_data_i[23:0];
        REG_DUTY_LIMIT:  duty_limit_q  <= cfg_data_i[24:0];
        default: ;
      endcase
    end
  end

  mppt_state_e state_q, state_d;

  // latched input word
  logic signed [31:0] pv_q, fv_q, fc_q;
  logic               on_q, en_q;
  logic               in_acc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pv_q <= pv_voltage_i;
      fv_q <= filt_voltage_i;
      fc_q <= filt_current_i;
      on_q <= converter_on_i;
      en_q <= mppt_enable_i;
    end
  end

  // ring memory: {voltage, current}
  logic [63:0] ring_mem [AVG_DEPTH];
  logic [63:0] rd_q;
  logic [IDX_W-1:0] idx_q;
  logic filled_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= ring_mem[idx_q];
    end
    if (state_q == ST_SUM) begin
      ring_mem[idx_q] <= {fv_q, fc_q};
    end
  end

  logic signed [SUM_W-1:0] vsum_q, isum_q;
  logic signed [SUM_W-1:0] old_v, old_i;
  logic [23:0] tick_q, tick_inc;
  logic armed_q;

  assign old_v = filled_q ? SUM_W'(signed'(rd_q[63:32])) : '0;
  assign old_i = filled_q ? SUM_W'(signed'(rd_q[31:0])) : '0;
  assign tick_inc = tick_q + 24'd1;

  // floor mean: arithmetic shift of the sums
  logic signed [31:0] vshift, ishift;
  logic signed [SUM_W-1:0] vsh_full, ish_full;

  assign vsh_full = vsum_q >>> IDX_W;
  assign ish_full = isum_q >>> IDX_W;
  assign vshift = vsh_full[31:0];
  assign ishift = ish_full[31:0];

  logic signed [31:0] avg_v_q, avg_i_q;
  logic signed [31:0] vref_q;
  logic signed [63:0] past_power_q;
  logic signed [31:0] past_avg_v_q;
  logic [24:0] integ_q;
  logic stepped_q;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [32:0]       err_q;
  logic [24:0]              duty_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_PWR: begin
        mul_a = MUL_W'(avg_v_q);
        mul_b = MUL_W'(avg_i_q);
      end
      ST_MULI: begin
        mul_a = signed'({2'b00, ki_ts_q});
        mul_b = MUL_W'(err_q);
      end
      ST_INTEG: begin
        mul_a = signed'({2'b00, kp_q});
        mul_b = MUL_W'(err_q);
      end
      ST_MULC: begin
        mul_a = signed'(MUL_W'({1'b0, duty_q}));
        mul_b = signed'(MUL_W'({1'b0, pwm_period_q}));
      end
      default: ;
    endcase
  end

  // hold the compare product while the result waits
  always_ff @(posedge clk_i) begin
    if (state_q != ST_FIN) prod_q <= mul_a * mul_b;
  end

  // step arithmetic
  logic signed [63:0] pw;
  logic signed [33:0] vref_w, step_w, r_mov, r_hi, r_cl, vmax_w, vmin_w;
  assign pw = prod_q[63:0];
  assign vref_w = 34'(vref_q);
  assign step_w = signed'({11'd0, v_step_q});
  assign vmax_w = signed'({9'd0, v_max_q});
  assign vmin_w = signed'({9'd0, v_min_q});

  always_comb begin
    r_mov = vref_w;
    if (pw > past_power_q) begin
      if (avg_v_q > past_avg_v_q) r_mov = vref_w + step_w;
      else if (avg_v_q < past_avg_v_q) r_mov = vref_w - step_w;
    end else if (pw < past_power_q) begin
      if (avg_v_q > past_avg_v_q) r_mov = vref_w - step_w;
      else if (avg_v_q < past_avg_v_q) r_mov = vref_w + step_w;
    end
    r_hi = (r_mov >= vmax_w) ? vmax_w : r_mov;
    r_cl = (r_hi <= vmin_w) ? vmin_w : r_hi;
  end

  // PI arithmetic
  logic signed [51:0] term;
  logic signed [27:0] inc;
  logic signed [28:0] integ_sum, dl_29;
  logic [24:0]        integ_new;
  logic signed [52:0] u, dl_53;
  logic [16:0]        cmp_raw;
  logic [15:0]        cmp_sat;

  assign term = prod_q[67:16];
  assign dl_29 = signed'({4'd0, duty_limit_q});
  assign dl_53 = signed'({28'd0, duty_limit_q});

  always_comb begin
    if (term > 52'(INC_MAX)) inc = INC_MAX;
    else if (term < -52'(INC_MAX)) inc = -INC_MAX;
    else inc = term[27:0];
    integ_sum = signed'({4'd0, integ_q}) + 29'(inc);
    if (integ_sum <= 29'sd0) integ_new = '0;
    else if (integ_sum >= dl_29) integ_new = duty_limit_q;
    else integ_new = integ_sum[24:0];
    u = 53'(term) + signed'({28'd0, integ_q});
    cmp_raw = prod_q[40:24];
    cmp_sat = cmp_raw[16] ? 16'hFFFF : cmp_raw[15:0];
  end

  logic out_valid_q, out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_RD;
      ST_RD:    state_d = ST_SUM;
      ST_SUM:   state_d = ST_AVG;
      ST_AVG: begin
        if (!on_q) state_d = ST_FIN;
        else if (armed_q && en_q) state_d = ST_PWR;
        else state_d = ST_ERR;
      end
      ST_PWR:   state_d = ST_STEP;
      ST_STEP:  state_d = ST_ERR;
      ST_ERR:   state_d = ST_MULI;
      ST_MULI:  state_d = ST_INTEG;
      ST_INTEG: state_d = ST_DUTY;
      ST_DUTY:  state_d = ST_MULC;
      ST_MULC:  state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsum_q       <= '0;
      isum_q       <= '0;
      idx_q        <= '0;
      filled_q     <= 1'b0;
      tick_q       <= '0;
      armed_q      <= 1'b0;
      vref_q       <= VREF_RST;
      integ_q      <= '0;
      past_power_q <= '0;
      past_avg_v_q <= '0;
      stepped_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: stepped_q <= 1'b0;
        ST_SUM: begin
          vsum_q <= vsum_q + SUM_W'(fv_q) - old_v;
          isum_q <= isum_q + SUM_W'(fc_q) - old_i;
          if (idx_q == IDX_LAST) begin
            idx_q    <= '0;
            filled_q <= 1'b1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
          if (tick_inc >= mppt_period_q) begin
            armed_q <= 1'b1;
            tick_q  <= '0;
          end else begin
            tick_q <= tick_inc;
          end
        end
        ST_AVG: begin
          if (!on_q) begin
            vref_q  <= pv_q;
            integ_q <= '0;
            armed_q <= 1'b0;
          end
        end
        ST_STEP: begin
          vref_q       <= r_cl[31:0];
          past_power_q <= pw;
          past_avg_v_q <= avg_v_q;
          armed_q      <= 1'b0;
          stepped_q    <= 1'b1;
        end
        ST_INTEG: integ_q <= integ_new;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_AVG: begin
        avg_v_q <= vshift;
        avg_i_q <= ishift;
      end
      ST_ERR: err_q <= 33'(pv_q) - 33'(vref_q);
      ST_DUTY: begin
        if (u >= dl_53) duty_q <= duty_limit_q;
        else if (u <= 53'sd0) duty_q <= '0;
        else duty_q <= u[24:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      compare_value_o     <= on_q ? cmp_sat : 16'd0;
      voltage_reference_o <= vref_q;
      average_voltage_o   <= avg_v_q;
      average_current_o   <= avg_i_q;
      mppt_stepped_o      <= stepped_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
